>>> hdl/pbrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preset bitmap rank/select package
// Shared sizes, operation codes and bit-counting helpers.
// ----------------------------------------------------------------------------
package pbrs_pkg;

    localparam int BITMAP_BYTES = 32;
    localparam int BYTE_W       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_MARK   = 3'd1;
    localparam logic [2:0] OP_COUNT  = 3'd2;
    localparam logic [2:0] OP_SELECT = 3'd3;
    localparam logic [2:0] OP_RANK   = 3'd4;
    localparam logic [2:0] OP_NEXT   = 3'd5;
    localparam logic [2:0] OP_PREV   = 3'd6;

    localparam logic [7:0] NONE_SLOT   = 8'hff;
    localparam logic [8:0] LIMIT_RESET = 9'd256;

    localparam logic [2:0] NIBBLE_ONES [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    // Number of set bits in one byte.
    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        byte_ones = 4'(NIBBLE_ONES[b[3:0]]) + 4'(NIBBLE_ONES[b[7:4]]);
    endfunction

    // Bit position of the rem-th set bit (1-based) in one byte.
    function automatic logic [2:0] nth_set_bit(input logic [7:0] b, input logic [3:0] rem);
        logic [3:0] cum;
        logic       hit;
        logic [2:0] pos;
        cum = 4'd0;
        hit = 1'b0;
        pos = 3'd0;
        for (int k = 0; k < 8; k++)
        begin
            cum = cum + 4'(b[k]);
            if (b[k] && (cum == rem) && !hit)
            begin
                pos = 3'(k);
                hit = 1'b1;
            end
        end
        nth_set_bit = pos;
    endfunction

endpackage

>>> hdl/preset_bitmap_rank_select.sv
`timescale 1ns / 1ps
// An accepted request walks the bitmap one byte per cycle: a first walk for
// clear, mark, count, select and rank, plus a second walk for next and
// previous when the count is not zero; the finish state then registers the
// result once the output register is free. A new request is accepted only in
// idle, after that hand-off; the single byte-wide popcount and search unit sets that pace.
// Reset clears the bitmap, sets count_limit to 256 and empties the output.
// ----------------------------------------------------------------------------
// Preset bitmap rank/select
// Keeps a 256-slot preset bitmap and answers clear, mark, count, select, rank
// and next/previous stepping requests with one result each.
// ----------------------------------------------------------------------------
module preset_bitmap_rank_select
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] slot_offset, [15:8] station_index
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [8:0] marked_count, [16:9] found_offset,
                                   // [24:17] result_index, [31:25] zero
    output logic        m_tuser,   // [0] found
    // count_limit write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    localparam int BW = pbrs_pkg::BYTE_W;
    localparam logic [BW-1:0] LAST_BYTE = BW'(pbrs_pkg::BITMAP_BYTES - 1);

    // Sequencer states: idle, first walk (update, count, select, rank),
    // second walk (select for stepping), and result hand-off.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PASS1  = 2'd1;
    localparam logic [1:0] ST_PASS2  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]    state_reg,  state_next;
    logic [BW-1:0] ptr_reg,    ptr_next;
    logic [8:0]    seen_reg,   seen_next;
    logic [2:0]    op_reg,     op_next;
    logic [7:0]    slot_reg,   slot_next;
    logic [7:0]    target_reg, target_next;
    logic [8:0]    cnt_reg,    cnt_next;
    logic [7:0]    off_reg,    off_next;
    logic [7:0]    res_reg,    res_next;
    logic          fnd_reg,    fnd_next;
    logic [8:0]    limit_reg,  limit_next;
    logic          mvalid_reg, mvalid_next;
    logic [31:0]   mdata_reg,  mdata_next;
    logic          muser_reg,  muser_next;

    // The bitmap itself, one register per byte, cleared by reset.
    logic [7:0] bitmap_reg [pbrs_pkg::BITMAP_BYTES];

    logic       in_fire;
    logic [7:0] byte_raw;
    logic [7:0] byte_next;
    logic       byte_wr;
    logic [3:0] byte_pop;
    logic [8:0] seen_sum;
    logic       hit_byte;
    logic       sel_active;
    logic       sel_hit;
    logic [3:0] sel_rem;
    logic [2:0] sel_bit;
    logic       rank_hit;
    logic [7:0] below_mask;
    logic [8:0] rank_pos;
    logic [8:0] cnt_sat;
    logic [7:0] total255;
    logic [7:0] step_raw;
    logic [7:0] step_idx;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    // ------------------------------------------------------------------
    // Shared byte unit: the byte under the walk pointer, updated for
    // clear or mark on the first walk, its popcount, and the select and
    // rank checks against the running count of marked slots before it.
    // ------------------------------------------------------------------
    assign byte_raw = bitmap_reg[ptr_reg];
    assign hit_byte = (5'(ptr_reg) == slot_reg[7:3]);

    always_comb
    begin
        byte_next = byte_raw;
        if (state_reg == ST_PASS1)
        begin
            if (op_reg == pbrs_pkg::OP_CLEAR)
            begin
                byte_next = 8'h00;
            end
            else if ((op_reg == pbrs_pkg::OP_MARK) && hit_byte)
            begin
                byte_next = byte_raw | (8'h01 << slot_reg[2:0]);
            end
        end
    end

    assign byte_wr  = (state_reg == ST_PASS1) &&
                      ((op_reg == pbrs_pkg::OP_CLEAR) || (op_reg == pbrs_pkg::OP_MARK));
    assign byte_pop = pbrs_pkg::byte_ones(byte_next);
    assign seen_sum = seen_reg + 9'(byte_pop);

    // Select: the wanted index falls inside this byte's share of marks.
    assign sel_active = (state_reg == ST_PASS2) ||
                        ((state_reg == ST_PASS1) && (op_reg == pbrs_pkg::OP_SELECT));
    assign sel_hit    = sel_active && !fnd_reg && (target_reg != 8'd0) &&
                        ({1'b0, target_reg} > seen_reg) &&
                        ({1'b0, target_reg} <= seen_sum);
    assign sel_rem    = 4'({1'b0, target_reg} - seen_reg);
    assign sel_bit    = pbrs_pkg::nth_set_bit(byte_next, sel_rem);

    // Rank: the slot is marked; its position counts the marks below it.
    assign rank_hit   = (state_reg == ST_PASS1) && (op_reg == pbrs_pkg::OP_RANK) &&
                        hit_byte && byte_next[slot_reg[2:0]];
    assign below_mask = (8'h01 << slot_reg[2:0]) - 8'h01;
    assign rank_pos   = seen_reg + 9'(pbrs_pkg::byte_ones(byte_next & below_mask)) + 9'd1;

    // Count at the end of the first walk, saturated at the limit.
    assign cnt_sat  = (seen_sum < limit_reg) ? seen_sum : limit_reg;
    assign total255 = cnt_sat[8] ? 8'hff : cnt_sat[7:0];
    assign step_raw = (op_reg == pbrs_pkg::OP_NEXT) ? (target_reg + 8'd1)
                                                     : (target_reg - 8'd1);

    always_comb
    begin
        if ((step_raw == 8'd0) || (step_raw == 8'hff))
        begin
            step_idx = total255;
        end
        else if (step_raw > total255)
        begin
            step_idx = 8'd1;
        end
        else
        begin
            step_idx = step_raw;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        seen_next   = seen_reg;
        op_next     = op_reg;
        slot_next   = slot_reg;
        target_next = target_reg;
        cnt_next    = cnt_reg;
        off_next    = off_reg;
        res_next    = res_reg;
        fnd_next    = fnd_reg;
        limit_next  = limit_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = s_tuser;
                    slot_next   = s_tdata[7:0];
                    target_next = s_tdata[15:8];
                    ptr_next    = '0;
                    seen_next   = 9'd0;
                    off_next    = pbrs_pkg::NONE_SLOT;
                    fnd_next    = 1'b0;
                    if ((s_tuser == pbrs_pkg::OP_SELECT) || (s_tuser == pbrs_pkg::OP_RANK) ||
                        (s_tuser == pbrs_pkg::OP_NEXT) || (s_tuser == pbrs_pkg::OP_PREV))
                    begin
                        res_next = s_tdata[15:8];
                    end
                    else
                    begin
                        res_next = 8'd0;
                    end
                    state_next = ST_PASS1;
                end
            end

            ST_PASS1, ST_PASS2:
            begin
                seen_next = seen_sum;
                ptr_next  = ptr_reg + BW'(1);
                if (sel_hit)
                begin
                    off_next = (8'(ptr_reg) << 3) | 8'(sel_bit);
                    fnd_next = 1'b1;
                end
                if (rank_hit)
                begin
                    res_next = rank_pos[8] ? 8'hff : rank_pos[7:0];
                    fnd_next = 1'b1;
                end
                if (ptr_reg == LAST_BYTE)
                begin
                    ptr_next   = '0;
                    seen_next  = 9'd0;
                    state_next = ST_FINISH;
                    if (state_reg == ST_PASS1)
                    begin
                        cnt_next = cnt_sat;
                        if (((op_reg == pbrs_pkg::OP_NEXT) || (op_reg == pbrs_pkg::OP_PREV)) &&
                            (total255 != 8'd0))
                        begin
                            res_next    = step_idx;
                            target_next = step_idx;
                            state_next  = ST_PASS2;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                // Hand the result over once the output register is free.
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {7'd0, res_reg, off_reg, cnt_reg};
                    muser_next  = fnd_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            limit_reg  <= pbrs_pkg::LIMIT_RESET;
            mvalid_reg <= 1'b0;
            ptr_reg    <= '0;
            seen_reg   <= 9'd0;
            fnd_reg    <= 1'b0;
            for (int i = 0; i < pbrs_pkg::BITMAP_BYTES; i++)
            begin
                bitmap_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg  <= state_next;
            limit_reg  <= limit_next;
            mvalid_reg <= mvalid_next;
            ptr_reg    <= ptr_next;
            seen_reg   <= seen_next;
            fnd_reg    <= fnd_next;
            if (byte_wr)
            begin
                bitmap_reg[ptr_reg] <= byte_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        target_reg <= target_next;
        cnt_reg    <= cnt_next;
        off_reg    <= off_next;
        res_reg    <= res_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

endmodule
